/* src/spjq_pkg.sv */
// Shared types and constants for the stable priority job queue.
`default_nettype none
package spjq_pkg;

   localparam int LIMIT_BITS  = 5;
   localparam int LIMIT_RESET = 16;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_TAKE  = 2'd1,
      ACT_CLOSE = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_ADDED      = 3'd0,
      ST_REJ_CLOSED = 3'd1,
      ST_REJ_FULL   = 3'd2,
      ST_TAKEN      = 3'd3,
      ST_EMPTY      = 3'd4,
      ST_CLOSED_NOW = 3'd5,
      ST_ALREADY    = 3'd6,
      ST_NOP        = 3'd7
   } status_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* src/stable_priority_job_queue.sv */
// Top level of the stable priority job queue: control, status and the row of slot cells.
`default_nettype none
// A bounded queue of tagged jobs kept sorted by priority, smallest first, equal
// priorities in arrival order. Each request (add, take, close) is accepted and its
// result appears in the response register on the next cycle; while req_stall is
// low a new request may enter every cycle. The rate is set by the compare-and-shift
// slot cells, which insert or pop a job per accepted request. req_stall rises only
// while a response is waiting and rsp_stall is high. queue_limit is written through
// the csr port, which is always ready; limits above QUEUE_DEPTH act as QUEUE_DEPTH.
module stable_priority_job_queue #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  spjq_pkg::action_type                    req_action,
   input  wire  [TAG_BITS-1:0]                     req_job_tag,
   input  wire  [PRIORITY_BITS-1:0]                req_job_priority,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output spjq_pkg::status_type                    rsp_status,
   output logic [TAG_BITS-1:0]                     rsp_taken_tag,
   output logic [PRIORITY_BITS-1:0]                rsp_taken_priority,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]        rsp_occupancy,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire  [spjq_pkg::LIMIT_BITS-1:0]         csr_data
);
   import spjq_pkg::*;

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     closed_ff, closed_in;
   logic [LIMIT_BITS-1:0]    limit_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [COUNT_BITS-1:0]    occ_ff;

   logic                     accept;
   logic                     full;
   cell_ctrl_type            ctrl;

   logic [QUEUE_DEPTH-1:0]   occupied;
   logic [QUEUE_DEPTH-1:0]   keep;
   logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]      cell_tag  [QUEUE_DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign full = (count_ff == COUNT_BITS'(QUEUE_DEPTH)) ||
                 (CMP_BITS'(count_ff) >= CMP_BITS'(limit_ff));

   always_comb begin
      ctrl      = '0;
      closed_in = closed_ff;
      count_in  = count_ff;
      status_in = ST_NOP;
      tag_in    = '0;
      prio_in   = '0;
      unique case (req_action)
         ACT_ADD: begin
            priority if (closed_ff) begin
               status_in = ST_REJ_CLOSED;
            end else if (full) begin
               status_in = ST_REJ_FULL;
            end else begin
               status_in   = ST_ADDED;
               ctrl.insert = accept;
               count_in    = count_ff + COUNT_BITS'(1);
            end
         end
         ACT_TAKE: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               status_in   = ST_TAKEN;
               ctrl.remove = accept;
               tag_in      = cell_tag[0];
               prio_in     = cell_prio[0];
               count_in    = count_ff - COUNT_BITS'(1);
            end
         end
         ACT_CLOSE: begin
            if (closed_ff) begin
               status_in = ST_ALREADY;
            end else begin
               status_in = ST_CLOSED_NOW;
               closed_in = 1'b1;
            end
         end
         ACT_NOP: begin
            status_in = ST_NOP;
         end
         default: begin
            status_in = ST_NOP;
         end
      endcase
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         limit_ff     <= LIMIT_BITS'(LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff  <= count_in;
            closed_ff <= closed_in;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         tag_ff    <= tag_in;
         prio_ff   <= prio_in;
         occ_ff    <= count_in;
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                     l_keep;
      logic [PRIORITY_BITS-1:0] l_prio, r_prio;
      logic [TAG_BITS-1:0]      l_tag, r_tag;

      assign occupied[i] = count_ff > COUNT_BITS'(i);

      if (i == 0) begin : g_head
         assign l_keep = 1'b1;
         assign l_prio = req_job_priority;
         assign l_tag  = req_job_tag;
      end else begin : g_body
         assign l_keep = keep[i-1];
         assign l_prio = cell_prio[i-1];
         assign l_tag  = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_prio = cell_prio[i];
         assign r_tag  = cell_tag[i];
      end else begin : g_inner
         assign r_prio = cell_prio[i+1];
         assign r_tag  = cell_tag[i+1];
      end

      spjq_cell #(
         .PRIORITY_BITS (PRIORITY_BITS),
         .TAG_BITS      (TAG_BITS)
      ) u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .new_priority   (req_job_priority),
         .new_tag        (req_job_tag),
         .occupied       (occupied[i]),
         .left_keep      (l_keep),
         .left_priority  (l_prio),
         .left_tag       (l_tag),
         .right_priority (r_prio),
         .right_tag      (r_tag),
         .keep           (keep[i]),
         .slot_priority  (cell_prio[i]),
         .slot_tag       (cell_tag[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_taken_tag      = tag_ff;
   assign rsp_taken_priority = prio_ff;
   assign rsp_occupancy      = occ_ff;

endmodule
`default_nettype wire

/* src/spjq_cell.sv */
// One slot of the sorted queue: holds a job, shifts right on insert, left on removal.
`default_nettype none
module spjq_cell #(
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  wire                          clock,
   input  spjq_pkg::cell_ctrl_type      ctrl,
   input  wire  [PRIORITY_BITS-1:0]     new_priority,
   input  wire  [TAG_BITS-1:0]          new_tag,
   input  wire                          occupied,
   input  wire                          left_keep,
   input  wire  [PRIORITY_BITS-1:0]     left_priority,
   input  wire  [TAG_BITS-1:0]          left_tag,
   input  wire  [PRIORITY_BITS-1:0]     right_priority,
   input  wire  [TAG_BITS-1:0]          right_tag,
   output logic                         keep,
   output logic [PRIORITY_BITS-1:0]     slot_priority,
   output logic [TAG_BITS-1:0]          slot_tag
);
   import spjq_pkg::*;

   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;

   // keep: this slot lies ahead of the insertion point
   assign keep          = occupied && (priority_ff <= new_priority);
   assign slot_priority = priority_ff;
   assign slot_tag      = tag_ff;

   always_comb begin
      priority_in = priority_ff;
      tag_in      = tag_ff;
      priority if (ctrl.insert && !keep) begin
         if (left_keep) begin
            priority_in = new_priority;
            tag_in      = new_tag;
         end else begin
            priority_in = left_priority;
            tag_in      = left_tag;
         end
      end else if (ctrl.remove) begin
         priority_in = right_priority;
         tag_in      = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      tag_ff      <= tag_in;
   end

endmodule
`default_nettype wire

/* src/spjq_checker.sv */
// Port-level checks for the stable priority job queue, bound to the top level.
`default_nettype none
module spjq_checker #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_stall,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input spjq_pkg::status_type             rsp_status,
   input wire [TAG_BITS-1:0]               rsp_taken_tag,
   input wire [PRIORITY_BITS-1:0]          rsp_taken_priority,
   input wire [$clog2(QUEUE_DEPTH+1)-1:0]  rsp_occupancy
);
   import spjq_pkg::*;

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_taken_tag) && $stable(rsp_taken_priority) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting response");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("occupancy beyond depth");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_TAKEN |-> rsp_taken_tag == '0 &&
      rsp_taken_priority == '0)
      else $error("taken fields set on a non-take item");

endmodule

bind stable_priority_job_queue spjq_checker #(
   .QUEUE_DEPTH   (QUEUE_DEPTH),
   .PRIORITY_BITS (PRIORITY_BITS),
   .TAG_BITS      (TAG_BITS)
) u_spjq_checker (.*);
`default_nettype wire
